### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the relaxation block. Each use sits
// on a line of its own and expects signals named clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/core/asgr_pkg.sv
// ----------------------------------------------------------------------------
// asgr_pkg
// Types and constants for the alternating-direction grid relaxation block.
// ----------------------------------------------------------------------------
`default_nettype none

package asgr_pkg;

  localparam int DATA_W    = 48;
  localparam int ERR_W     = 47;
  localparam int ITER_W    = 10;
  localparam int SIZE_W    = 7;
  localparam int POS_W     = 6;
  localparam int CFG_W     = 47;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_THRESHOLD = 2'd2;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RST     = 7'd64;
  localparam logic [ITER_W-1:0] ITER_LIMIT_RST    = 10'd100;
  localparam logic [ERR_W-1:0]  ERR_THRESHOLD_RST = 47'd43;

  localparam logic [ERR_W-1:0] ERR_MAX = 47'h7FFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_RUN   = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_SUM,
    S_WR,
    S_ERR,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [DATA_W-1:0] cell_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] cell_out;
    logic [ITER_W-1:0]        iterations_done;
    logic [ERR_W-1:0]         final_error;
    logic                     converged;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/core/asgr_grid_mem.sv
// ----------------------------------------------------------------------------
// asgr_grid_mem
// Grid store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module asgr_grid_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 48
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/alternating_sweep_grid_relaxation_top.sv
// ----------------------------------------------------------------------------
// alternating_sweep_grid_relaxation_top
// Square grid relaxation by alternating column and row sweeps over a store.
// ----------------------------------------------------------------------------
// A command word is taken at a clock edge where start is high and busy is low,
// and every command gives exactly one result word on out_data, marked by
// out_strobe for a single cycle; the receiver cannot hold it off, so it must
// capture the word in that cycle. Cell writes, cell reads and unknown commands
// keep busy low and may follow one another every cycle; their result appears
// in the cycle after acceptance. A run raises busy until its result: a start
// step, then per iteration a column sweep and a row sweep over the interior
// cells and a check step; each cell in the column sweep reads two neighbours,
// sums and writes, and in the row sweep also reads the cell's old value and
// updates the error. The grid store's single read port sets this pace, since
// each updated cell needs its neighbours read one after another. The store is
// not cleared: every cell in use must be written before it is read or run over.
`default_nettype none

`include "assert_macros.svh"

module alternating_sweep_grid_relaxation_top #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire asgr_pkg::in_word_t                   in_data,
  output logic                                      out_strobe,
  output asgr_pkg::out_word_t                       out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [asgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [asgr_pkg::CFG_W-1:0]           cfg_data
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int N_W    = ($clog2(MAX_SIDE + 1) > asgr_pkg::SIZE_W) ?
                          $clog2(MAX_SIDE + 1) : asgr_pkg::SIZE_W;
  localparam int DW     = asgr_pkg::DATA_W;
  localparam int EW     = asgr_pkg::ERR_W;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);
  endfunction

  // Configuration
  logic [asgr_pkg::SIZE_W-1:0] grid_size_r;
  logic [asgr_pkg::ITER_W-1:0] iter_limit_r;
  logic [EW-1:0]               err_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r  <= asgr_pkg::GRID_SIZE_RST;
      iter_limit_r <= asgr_pkg::ITER_LIMIT_RST;
      err_thr_r    <= asgr_pkg::ERR_THRESHOLD_RST;
    end else if (cfg_we) begin
      priority case (cfg_index)
        asgr_pkg::CFG_GRID_SIZE:     grid_size_r  <= cfg_data[asgr_pkg::SIZE_W-1:0];
        asgr_pkg::CFG_ITER_LIMIT:    iter_limit_r <= cfg_data[asgr_pkg::ITER_W-1:0];
        asgr_pkg::CFG_ERR_THRESHOLD: err_thr_r    <= cfg_data[EW-1:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers
  asgr_pkg::state_t            state_r, state_nxt;
  logic [IDX_W-1:0]            i_r, i_nxt, j_r, j_nxt, lim_r, lim_nxt;
  logic                        row_phase_r, row_phase_nxt;
  logic                        small_r, small_nxt;
  logic [asgr_pkg::ITER_W-1:0] it_r, it_nxt;
  logic [EW-1:0]               err_r, err_nxt;
  logic                        conv_r, conv_nxt;
  logic                        out_strobe_r, out_strobe_nxt;
  logic                        out_run_r, out_run_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic [DW-1:0]               a_r, a_nxt, b_r, b_nxt, old_r, old_nxt, nv_r, nv_nxt;
  logic [DW:0]                 diff_r, diff_nxt;

  // Grid store ports
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0]     mem_wdata, mem_rdata;

  asgr_grid_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DW)
  ) u_grid_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Host cell address and range check
  logic [N_W-1:0]    host_row_ext, host_col_ext, n_eff;
  logic              host_in_range;
  logic [ADDR_W-1:0] host_addr;
  logic              accept;

  assign accept        = start && !busy;
  assign host_row_ext  = N_W'(in_data.row);
  assign host_col_ext  = N_W'(in_data.col);
  assign host_in_range = (host_row_ext < N_W'(MAX_SIDE)) && (host_col_ext < N_W'(MAX_SIDE));
  assign host_addr     = cell_addr(IDX_W'(in_data.row), IDX_W'(in_data.col));
  assign n_eff         = (N_W'(grid_size_r) > N_W'(MAX_SIDE)) ? N_W'(MAX_SIDE)
                                                              : N_W'(grid_size_r);

  // Sweep arithmetic
  logic [DW:0]   sum;
  logic [DW-1:0] b_sel;
  logic [DW:0]   abs_diff;
  logic [EW-1:0] sat_diff;

  assign b_sel    = row_phase_r ? b_r : mem_rdata;
  assign sum      = {a_r[DW-1], a_r} + {b_sel[DW-1], b_sel};
  assign abs_diff = diff_r[DW] ? (~diff_r + (DW+1)'(1)) : diff_r;
  assign sat_diff = (abs_diff > {2'b00, asgr_pkg::ERR_MAX}) ? asgr_pkg::ERR_MAX
                                                            : abs_diff[EW-1:0];

  // Where the sweep goes after the current cell.
  asgr_pkg::state_t  step_state;
  logic [IDX_W-1:0]  step_i, step_j;
  logic              step_phase;

  always_comb begin
    step_state = asgr_pkg::S_RD_A;
    step_i     = i_r;
    step_j     = j_r;
    step_phase = row_phase_r;
    if (i_r == lim_r) begin
      step_i = IDX_W'(1);
      if (j_r == lim_r) begin
        step_j = IDX_W'(1);
        if (row_phase_r) begin
          step_state = asgr_pkg::S_CHECK;
        end else begin
          step_phase = 1'b1;
        end
      end else begin
        step_j = j_r + IDX_W'(1);
      end
    end else begin
      step_i = i_r + IDX_W'(1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    lim_nxt        = lim_r;
    row_phase_nxt  = row_phase_r;
    small_nxt      = small_r;
    it_nxt         = it_r;
    err_nxt        = err_r;
    conv_nxt       = conv_r;
    out_strobe_nxt = 1'b0;
    out_run_nxt    = out_run_r;
    rd_pend_nxt    = 1'b0;
    a_nxt          = a_r;
    b_nxt          = b_r;
    old_nxt        = old_r;
    nv_nxt         = nv_r;
    diff_nxt       = diff_r;
    mem_we         = 1'b0;
    mem_waddr      = host_addr;
    mem_wdata      = in_data.cell_in;
    mem_re         = 1'b0;
    mem_raddr      = host_addr;

    unique case (state_r)
      asgr_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_data.cmd)
            asgr_pkg::CMD_WRITE: begin
              mem_we         = host_in_range;
              out_strobe_nxt = 1'b1;
              out_run_nxt    = 1'b0;
            end
            asgr_pkg::CMD_READ: begin
              mem_re         = host_in_range;
              rd_pend_nxt    = host_in_range;
              out_strobe_nxt = 1'b1;
              out_run_nxt    = 1'b0;
            end
            asgr_pkg::CMD_RUN: begin
              state_nxt = asgr_pkg::S_START;
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_run_nxt    = 1'b0;
            end
          endcase
        end
      end

      asgr_pkg::S_START: begin
        it_nxt        = '0;
        err_nxt       = '0;
        conv_nxt      = 1'b0;
        i_nxt         = IDX_W'(1);
        j_nxt         = IDX_W'(1);
        row_phase_nxt = 1'b0;
        lim_nxt       = IDX_W'(n_eff - N_W'(2));
        small_nxt     = n_eff < N_W'(3);
        if (iter_limit_r == '0) begin
          state_nxt      = asgr_pkg::S_IDLE;
          out_strobe_nxt = 1'b1;
          out_run_nxt    = 1'b1;
        end else if (n_eff < N_W'(3)) begin
          state_nxt = asgr_pkg::S_CHECK;
        end else begin
          state_nxt = asgr_pkg::S_RD_A;
        end
      end

      asgr_pkg::S_RD_A: begin
        mem_re    = 1'b1;
        mem_raddr = row_phase_r ? cell_addr(i_r, j_r - IDX_W'(1))
                                : cell_addr(i_r - IDX_W'(1), j_r);
        state_nxt = asgr_pkg::S_RD_B;
      end

      asgr_pkg::S_RD_B: begin
        mem_re    = 1'b1;
        mem_raddr = row_phase_r ? cell_addr(i_r, j_r + IDX_W'(1))
                                : cell_addr(i_r + IDX_W'(1), j_r);
        a_nxt     = mem_rdata;
        state_nxt = row_phase_r ? asgr_pkg::S_RD_C : asgr_pkg::S_SUM;
      end

      asgr_pkg::S_RD_C: begin
        mem_re    = 1'b1;
        mem_raddr = cell_addr(i_r, j_r);
        b_nxt     = mem_rdata;
        state_nxt = asgr_pkg::S_SUM;
      end

      asgr_pkg::S_SUM: begin
        // In the row sweep the read data is the cell's old value.
        old_nxt   = mem_rdata;
        nv_nxt    = sum[DW:1];
        state_nxt = asgr_pkg::S_WR;
      end

      asgr_pkg::S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(i_r, j_r);
        mem_wdata = nv_r;
        diff_nxt  = {old_r[DW-1], old_r} - {nv_r[DW-1], nv_r};
        if (row_phase_r) begin
          state_nxt = asgr_pkg::S_ERR;
        end else begin
          state_nxt     = step_state;
          i_nxt         = step_i;
          j_nxt         = step_j;
          row_phase_nxt = step_phase;
        end
      end

      asgr_pkg::S_ERR: begin
        if (sat_diff > err_r) begin
          err_nxt = sat_diff;
        end
        state_nxt     = step_state;
        i_nxt         = step_i;
        j_nxt         = step_j;
        row_phase_nxt = step_phase;
      end

      asgr_pkg::S_CHECK: begin
        it_nxt = it_r + asgr_pkg::ITER_W'(1);
        if (err_r < err_thr_r) begin
          conv_nxt       = 1'b1;
          state_nxt      = asgr_pkg::S_IDLE;
          out_strobe_nxt = 1'b1;
          out_run_nxt    = 1'b1;
        end else if ((it_r + asgr_pkg::ITER_W'(1)) == iter_limit_r) begin
          state_nxt      = asgr_pkg::S_IDLE;
          out_strobe_nxt = 1'b1;
          out_run_nxt    = 1'b1;
        end else begin
          err_nxt       = '0;
          row_phase_nxt = 1'b0;
          i_nxt         = IDX_W'(1);
          j_nxt         = IDX_W'(1);
          state_nxt     = small_r ? asgr_pkg::S_CHECK : asgr_pkg::S_RD_A;
        end
      end

      default: begin
        state_nxt = asgr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= asgr_pkg::S_IDLE;
      i_r          <= IDX_W'(1);
      j_r          <= IDX_W'(1);
      lim_r        <= IDX_W'(1);
      row_phase_r  <= 1'b0;
      small_r      <= 1'b0;
      it_r         <= '0;
      err_r        <= '0;
      conv_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      out_run_r    <= 1'b0;
      rd_pend_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      lim_r        <= lim_nxt;
      row_phase_r  <= row_phase_nxt;
      small_r      <= small_nxt;
      it_r         <= it_nxt;
      err_r        <= err_nxt;
      conv_r       <= conv_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_run_r    <= out_run_nxt;
      rd_pend_r    <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    old_r  <= old_nxt;
    nv_r   <= nv_nxt;
    diff_r <= diff_nxt;
  end

  assign busy       = (state_r != asgr_pkg::S_IDLE);
  assign out_strobe = out_strobe_r;

  always_comb begin
    out_data                 = '0;
    out_data.cell_out        = rd_pend_r ? mem_rdata : '0;
    out_data.iterations_done = out_run_r ? it_r : '0;
    out_data.final_error     = out_run_r ? err_r : '0;
    out_data.converged       = out_run_r && conv_r;
  end

  `ASSERT_CLK(a_run_goes_busy, (accept && in_data.cmd == asgr_pkg::CMD_RUN) |=> busy, "run command did not raise busy")
  `ASSERT_CLK(a_host_word_result, (accept && in_data.cmd != asgr_pkg::CMD_RUN) |=> out_strobe, "host word gave no result next cycle")
  `ASSERT_CLK(a_iter_in_limit, (out_strobe && out_run_r) |-> (it_r <= iter_limit_r), "iteration count beyond limit")
  `ASSERT_CLK(a_conv_below_thr, (out_strobe && out_data.converged) |-> (out_data.final_error < err_thr_r), "converged with error not below threshold")
  `ASSERT_NEVER(a_sweep_interior, (state_r == asgr_pkg::S_RD_A) && (i_r == '0 || j_r == '0 || i_r > lim_r || j_r > lim_r), "sweep left the grid interior")

endmodule

`default_nettype wire
